[rtl/hsss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Half-step sequencer package
// Shared widths, operation and register codes, the step conversion constants
// and the eight-phase coil pattern table.
// ----------------------------------------------------------------------------
package hsss_pkg;

	localparam int ANGLE_FRAC_BITS = 4;

	localparam int OP_W    = 2;
	localparam int ANGLE_W = 18;
	localparam int MAG_W   = 18;
	localparam int SPR_W   = 16;
	localparam int DELAY_W = 8;
	localparam int STEP_W  = 16;
	localparam int COIL_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 1'd1;

	localparam logic [DELAY_W-1:0] STEP_DELAY_RESET    = 8'd2;
	localparam logic [SPR_W-1:0]   STEPS_PER_REV_RESET = 16'd2720;

	// One revolution is 360 << ANGLE_FRAC_BITS units, which is 45 << (3 + ANGLE_FRAC_BITS).
	localparam int PROD_W      = MAG_W + SPR_W;
	localparam int DEN_SHIFT   = 3 + ANGLE_FRAC_BITS;
	localparam int QUOT_IN_W   = PROD_W - DEN_SHIFT;
	localparam int DIV_ODD     = 45;
	localparam int RECIP_SHIFT = 37;
	localparam int RECIP_W     = 32;
	localparam logic [RECIP_W-1:0] RECIP_45 =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));
	localparam int QUOT_W      = QUOT_IN_W + RECIP_W - RECIP_SHIFT;

	function automatic logic [COIL_W-1:0] coil_of_phase(input logic [2:0] ph);
		logic [COIL_W-1:0] c;
		case (ph)
			3'd0: c = 4'hE;
			3'd1: c = 4'hC;
			3'd2: c = 4'hD;
			3'd3: c = 4'h9;
			3'd4: c = 4'hB;
			3'd5: c = 4'h3;
			3'd6: c = 4'h7;
			default: c = 4'h6;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/hsss_step_conv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Step count conversion
// Divides the registered angle-times-resolution product by one revolution
// through a shift and a reciprocal multiplication, and saturates to 16 bits.
// ----------------------------------------------------------------------------
module hsss_step_conv
	import hsss_pkg::*;
(
	input  wire logic [PROD_W-1:0] prod,
	output logic      [STEP_W-1:0] steps
);

	logic [QUOT_IN_W-1:0]         num;
	logic [QUOT_IN_W+RECIP_W-1:0] scaled;
	logic [QUOT_W-1:0]            quot;

	assign num    = prod[PROD_W-1:DEN_SHIFT];
	assign scaled = (QUOT_IN_W+RECIP_W)'(num) * (QUOT_IN_W+RECIP_W)'(RECIP_45);
	assign quot   = scaled[QUOT_IN_W+RECIP_W-1:RECIP_SHIFT];
	assign steps  = (|quot[QUOT_W-1:STEP_W]) ? {STEP_W{1'b1}} : quot[STEP_W-1:0];

endmodule
`default_nettype wire

[rtl/half_step_stepper_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Half-step stepper sequencer
// Four-coil eight-phase stepper driver taking tick, move and stop requests.
// ----------------------------------------------------------------------------
// Each request gives one result, which reaches the outputs through both
// stages and the output register, and a new request is accepted in every
// cycle in which the pipeline does not hold. The first stage takes the angle
// magnitude, the second holds the product with the steps-per-revolution
// register, and the third divides by one revolution, updates the step state
// and loads the output register. The pipeline holds only when the output
// register and both stages are full and the result is not taken.
module half_step_stepper_sequencer
	import hsss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [OP_W-1:0]       operation,
	input  wire logic signed [ANGLE_W-1:0] angle_q4,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [COIL_W-1:0]     coil_pattern,
	output logic                       busy_res,
	output logic                       rejected,
	output logic      [STEP_W-1:0]     steps_left,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic               valid_s1, valid_s2, out_valid_q;
	logic [OP_W-1:0]    op_s1, op_s2;
	logic               neg_s1, neg_s2;
	logic [MAG_W-1:0]   mag_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic [DELAY_W-1:0] step_delay_q;
	logic [SPR_W-1:0]   steps_per_rev_q;
	logic [STEP_W-1:0]  step_index_q;
	logic [DELAY_W-1:0] hold_count_q;
	logic               reverse_dir_q;
	logic [COIL_W-1:0]  coil_reg_q;
	logic [COIL_W-1:0]  coil_out_q;
	logic               busy_out_q, rej_out_q;
	logic [STEP_W-1:0]  steps_out_q;

	logic               out_free, adv_s2, adv_s1;
	logic [MAG_W-1:0]   mag_in;
	logic [STEP_W-1:0]  conv_steps;
	logic [STEP_W-1:0]  idx_d, idx_dec;
	logic [DELAY_W-1:0] hold_d;
	logic               rev_d, rej_d;
	logic [COIL_W-1:0]  coil_d;

	assign out_free = ~out_valid_q | ~out_stall;
	assign adv_s2   = ~valid_s2 | out_free;
	assign adv_s1   = ~valid_s1 | adv_s2;
	assign in_stall = ~adv_s1;
	assign cfg_ready = 1'b1;

	assign mag_in = angle_q4[ANGLE_W-1] ? MAG_W'(-angle_q4) : MAG_W'(angle_q4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (out_free)
				out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1  <= operation;
			neg_s1 <= angle_q4[ANGLE_W-1];
			mag_s1 <= mag_in;
		end
		if (adv_s2 && valid_s1) begin
			op_s2   <= op_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(steps_per_rev_q);
		end
		if (out_free && valid_s2) begin
			coil_out_q  <= coil_d;
			busy_out_q  <= (idx_d != '0);
			rej_out_q   <= rej_d;
			steps_out_q <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_delay_q    <= STEP_DELAY_RESET;
			steps_per_rev_q <= STEPS_PER_REV_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STEP_DELAY:    step_delay_q    <= cfg_data[DELAY_W-1:0];
				REG_STEPS_PER_REV: steps_per_rev_q <= cfg_data[SPR_W-1:0];
				default: ;
			endcase
		end
	end

	hsss_step_conv u_step_conv (
		.prod  (prod_s2),
		.steps (conv_steps)
	);

	always_comb begin
		idx_d   = step_index_q;
		hold_d  = hold_count_q;
		rev_d   = reverse_dir_q;
		coil_d  = coil_reg_q;
		rej_d   = 1'b0;
		idx_dec = step_index_q - STEP_W'(1);
		unique case (op_s2)
			OP_TICK: begin
				if (step_index_q != '0) begin
					if (hold_count_q <= DELAY_W'(1)) begin
						idx_d = idx_dec;
						if (idx_dec != '0) begin
							coil_d = coil_of_phase(reverse_dir_q ? ~idx_dec[2:0] : idx_dec[2:0]);
							hold_d = step_delay_q;
						end else begin
							hold_d = '0;
						end
					end else begin
						hold_d = hold_count_q - DELAY_W'(1);
					end
				end
			end
			OP_MOVE: begin
				if (step_index_q != '0) begin
					rej_d = 1'b1;
				end else if (conv_steps != '0) begin
					idx_d  = conv_steps;
					rev_d  = neg_s2;
					coil_d = coil_of_phase(neg_s2 ? ~conv_steps[2:0] : conv_steps[2:0]);
					hold_d = step_delay_q;
				end
			end
			OP_STOP: begin
				coil_d = '0;
				idx_d  = '0;
				hold_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_index_q  <= '0;
			hold_count_q  <= '0;
			reverse_dir_q <= 1'b0;
			coil_reg_q    <= '0;
		end else if (out_free && valid_s2) begin
			step_index_q  <= idx_d;
			hold_count_q  <= hold_d;
			reverse_dir_q <= rev_d;
			coil_reg_q    <= coil_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign coil_pattern = coil_out_q;
	assign busy_res     = busy_out_q;
	assign rejected     = rej_out_q;
	assign steps_left   = steps_out_q;

endmodule
`default_nettype wire
